/* design/jslec_pkg.sv */
`timescale 1ns / 1ps

package jslec_pkg;

   localparam int DW        = 32;
   localparam int GAIN_W    = 31;
   localparam int FRAC_W    = 16;
   localparam int DIFF_W    = DW + 1;
   localparam int PROD_W    = DIFF_W + GAIN_W + 1;
   localparam int Q_W       = PROD_W - 1 - FRAC_W;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] REG_ENABLE        = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_CONTINUOUS    = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_SOFT_POS_HIGH = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_SOFT_POS_LOW  = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_LIMIT   = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] REG_POSITION_GAIN = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] REG_TORQUE_LIMIT  = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] REG_VELOCITY_GAIN = CSR_IDX_W'(7);

   localparam logic signed [DW-1:0] SPEED_LIMIT_RESET = -DW'(65536);

   typedef struct packed {
      logic                 valid;
      logic signed [DW-1:0] velocity;
      logic signed [DW-1:0] effort;
   } ctl_type;

   typedef struct packed {
      logic                 continuous_joint;
      logic signed [DW-1:0] soft_position_high;
      logic signed [DW-1:0] soft_position_low;
      logic signed [DW-1:0] speed_limit;
      logic [GAIN_W-1:0]    position_gain;
      logic [GAIN_W-1:0]    torque_limit;
      logic [GAIN_W-1:0]    velocity_gain;
   } cfg_type;

   function automatic logic signed [DW-1:0] sat_dw(input logic signed [Q_W-1:0] v);
      logic signed [Q_W-1:0] hi;
      logic signed [Q_W-1:0] lo;
      hi = $signed({{(Q_W-DW+1){1'b0}}, {(DW-1){1'b1}}});
      lo = ~hi;
      if (v > hi) begin
         return hi[DW-1:0];
      end else if (v < lo) begin
         return lo[DW-1:0];
      end
      return v[DW-1:0];
   endfunction

endpackage

/* design/jslec_gain_mul.sv */
`timescale 1ns / 1ps

module jslec_gain_mul
   import jslec_pkg::*;
(
   input  logic                     clock,
   input  logic                     advance,
   input  logic [GAIN_W-1:0]        gain,
   input  logic signed [DIFF_W-1:0] diff,
   output logic signed [Q_W-1:0]    quot_ff
);

   logic signed [PROD_W-1:0] prod;
   logic signed [Q_W-1:0]    quot_in;

   assign prod    = PROD_W'(diff) * PROD_W'($signed({1'b0, gain}));
   assign quot_in = prod[PROD_W-2:FRAC_W];

   always_ff @(posedge clock) begin
      if (advance) begin
         quot_ff <= quot_in;
      end
   end

endmodule

/* design/jslec_vel_bound.sv */
`timescale 1ns / 1ps

module jslec_vel_bound
   import jslec_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  cfg_type              cfg,
   input  ctl_type              in_ctl,
   input  logic signed [DW-1:0] in_position,
   input  logic                 in_calibrated,
   output ctl_type              out_ctl,
   output logic signed [DW-1:0] vel_upper_ff,
   output logic signed [DW-1:0] vel_lower_ff
);

   ctl_type                  ctl1_ff, ctl2_ff;
   logic                     bounded1_ff, bounded2_ff;
   logic signed [DIFF_W-1:0] diff_high_in, diff_low_in, diff_high_ff, diff_low_ff;
   logic signed [Q_W-1:0]    prod_high, prod_low;
   logic signed [Q_W-1:0]    speed_q, neg_speed_q, high_q, low_q;
   logic signed [DW-1:0]     vel_upper_in, vel_lower_in;
   ctl_type                  ctl3_ff;

   assign diff_high_in = $signed({cfg.soft_position_high[DW-1], cfg.soft_position_high})
                       - $signed({in_position[DW-1], in_position});
   assign diff_low_in  = $signed({cfg.soft_position_low[DW-1], cfg.soft_position_low})
                       - $signed({in_position[DW-1], in_position});

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
      end else if (advance) begin
         ctl1_ff <= in_ctl;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         diff_high_ff <= diff_high_in;
         diff_low_ff  <= diff_low_in;
         bounded1_ff  <= in_calibrated & ~cfg.continuous_joint;
         bounded2_ff  <= bounded1_ff;
         vel_upper_ff <= vel_upper_in;
         vel_lower_ff <= vel_lower_in;
      end
   end

   jslec_gain_mul u_mul_high (
      .clock   (clock),
      .advance (advance),
      .gain    (cfg.position_gain),
      .diff    (diff_high_ff),
      .quot_ff (prod_high)
   );

   jslec_gain_mul u_mul_low (
      .clock   (clock),
      .advance (advance),
      .gain    (cfg.position_gain),
      .diff    (diff_low_ff),
      .quot_ff (prod_low)
   );

   assign speed_q     = $signed({{(Q_W-DW){cfg.speed_limit[DW-1]}}, cfg.speed_limit});
   assign neg_speed_q = -speed_q;

   always_comb begin
      high_q = speed_q;
      low_q  = neg_speed_q;
      if (bounded2_ff && (prod_high < speed_q)) begin
         high_q = prod_high;
      end
      if (bounded2_ff && (prod_low > neg_speed_q)) begin
         low_q = prod_low;
      end
   end

   assign vel_upper_in = sat_dw(high_q);
   assign vel_lower_in = sat_dw(low_q);
   assign out_ctl      = ctl3_ff;

   a_vel_upper_capped: assert property (@(posedge clock) disable iff (reset)
      ctl3_ff.valid |-> (vel_upper_ff <= cfg.speed_limit))
      else $error("velocity upper bound above speed limit");

endmodule

/* design/jslec_eff_bound.sv */
`timescale 1ns / 1ps

module jslec_eff_bound
   import jslec_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  cfg_type              cfg,
   input  ctl_type              in_ctl,
   input  logic signed [DW-1:0] in_vel_upper,
   input  logic signed [DW-1:0] in_vel_lower,
   output ctl_type              out_ctl,
   output logic signed [DW-1:0] eff_high_ff,
   output logic signed [DW-1:0] eff_low_ff
);

   ctl_type                  ctl1_ff, ctl2_ff, ctl3_ff;
   logic signed [DIFF_W-1:0] diff_high_in, diff_low_in, diff_high_ff, diff_low_ff;
   logic signed [Q_W-1:0]    prod_high, prod_low;
   logic signed [Q_W-1:0]    torque_q, neg_torque_q, high_q, low_q;
   logic signed [DW-1:0]     eff_high_in, eff_low_in;
   logic                     speed_limited;

   assign diff_high_in = $signed({in_vel_upper[DW-1], in_vel_upper})
                       - $signed({in_ctl.velocity[DW-1], in_ctl.velocity});
   assign diff_low_in  = $signed({in_vel_lower[DW-1], in_vel_lower})
                       - $signed({in_ctl.velocity[DW-1], in_ctl.velocity});

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
      end else if (advance) begin
         ctl1_ff <= in_ctl;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         diff_high_ff <= diff_high_in;
         diff_low_ff  <= diff_low_in;
         eff_high_ff  <= eff_high_in;
         eff_low_ff   <= eff_low_in;
      end
   end

   jslec_gain_mul u_mul_high (
      .clock   (clock),
      .advance (advance),
      .gain    (cfg.velocity_gain),
      .diff    (diff_high_ff),
      .quot_ff (prod_high)
   );

   jslec_gain_mul u_mul_low (
      .clock   (clock),
      .advance (advance),
      .gain    (cfg.velocity_gain),
      .diff    (diff_low_ff),
      .quot_ff (prod_low)
   );

   assign speed_limited = ~cfg.speed_limit[DW-1];
   assign torque_q      = $signed({{(Q_W-GAIN_W){1'b0}}, cfg.torque_limit});
   assign neg_torque_q  = -torque_q;

   always_comb begin
      high_q = torque_q;
      low_q  = neg_torque_q;
      if (speed_limited && (prod_high < torque_q)) begin
         high_q = prod_high;
      end
      if (speed_limited && (prod_low > neg_torque_q)) begin
         low_q = prod_low;
      end
   end

   assign eff_high_in = sat_dw(high_q);
   assign eff_low_in  = sat_dw(low_q);
   assign out_ctl     = ctl3_ff;

   a_eff_high_capped: assert property (@(posedge clock) disable iff (reset)
      ctl3_ff.valid |-> (eff_high_ff <= $signed({1'b0, cfg.torque_limit})))
      else $error("effort high bound above torque limit");

endmodule

/* design/joint_soft_limit_effort_clamp_core.sv */
`timescale 1ns / 1ps

// Safety clamp on one joint's commanded effort, Q16.16 throughout. Takes one sample per
// clock unless stalled and returns one clamped effort per sample, in order, through the
// registered stages: position difference, position-gain multiply, velocity bounds, velocity
// difference, velocity-gain multiply, effort bounds, final clamp. The two 33x32 multiply
// stages set the depth. A stall on the result side holds the whole pipeline and the
// input stalls with it. Write the csr registers only with the pipeline empty.

module joint_soft_limit_effort_clamp_core
   import jslec_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DW-1:0]        csr_wdata,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [DW-1:0] req_joint_position,
   input  logic signed [DW-1:0] req_joint_velocity,
   input  logic signed [DW-1:0] req_requested_effort,
   input  logic                 req_is_calibrated,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [DW-1:0] rsp_limited_effort
);

   logic                 enable_ff;
   logic                 continuous_ff;
   logic signed [DW-1:0] soft_high_ff, soft_low_ff, speed_limit_ff;
   logic [GAIN_W-1:0]    position_gain_ff, torque_limit_ff, velocity_gain_ff;
   cfg_type              cfg;
   logic                 advance;
   ctl_type              in_ctl, vel_ctl, eff_ctl;
   logic signed [DW-1:0] vel_upper, vel_lower, eff_high, eff_low;
   logic signed [DW-1:0] lower, result_in, result_ff;
   logic                 valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff        <= 1'b0;
         continuous_ff    <= 1'b0;
         soft_high_ff     <= '0;
         soft_low_ff      <= '0;
         speed_limit_ff   <= SPEED_LIMIT_RESET;
         position_gain_ff <= '0;
         torque_limit_ff  <= '0;
         velocity_gain_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_ENABLE:        enable_ff        <= csr_wdata[0];
            REG_CONTINUOUS:    continuous_ff    <= csr_wdata[0];
            REG_SOFT_POS_HIGH: soft_high_ff     <= csr_wdata;
            REG_SOFT_POS_LOW:  soft_low_ff      <= csr_wdata;
            REG_SPEED_LIMIT:   speed_limit_ff   <= csr_wdata;
            REG_POSITION_GAIN: position_gain_ff <= csr_wdata[GAIN_W-1:0];
            REG_TORQUE_LIMIT:  torque_limit_ff  <= csr_wdata[GAIN_W-1:0];
            REG_VELOCITY_GAIN: velocity_gain_ff <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.continuous_joint   = continuous_ff;
   assign cfg.soft_position_high = soft_high_ff;
   assign cfg.soft_position_low  = soft_low_ff;
   assign cfg.speed_limit        = speed_limit_ff;
   assign cfg.position_gain      = position_gain_ff;
   assign cfg.torque_limit       = torque_limit_ff;
   assign cfg.velocity_gain      = velocity_gain_ff;

   // hold every stage while a finished result waits
   assign advance   = ~(valid_ff & rsp_stall);
   assign req_stall = ~advance;

   assign in_ctl.valid    = req_valid;
   assign in_ctl.velocity = req_joint_velocity;
   assign in_ctl.effort   = req_requested_effort;

   jslec_vel_bound u_vel (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .cfg           (cfg),
      .in_ctl        (in_ctl),
      .in_position   (req_joint_position),
      .in_calibrated (req_is_calibrated),
      .out_ctl       (vel_ctl),
      .vel_upper_ff  (vel_upper),
      .vel_lower_ff  (vel_lower)
   );

   jslec_eff_bound u_eff (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .cfg          (cfg),
      .in_ctl       (vel_ctl),
      .in_vel_upper (vel_upper),
      .in_vel_lower (vel_lower),
      .out_ctl      (eff_ctl),
      .eff_high_ff  (eff_high),
      .eff_low_ff   (eff_low)
   );

   // low bound first, then high, so high wins on crossed bounds
   assign lower     = (eff_ctl.effort < eff_low) ? eff_low : eff_ctl.effort;
   assign result_in = ~enable_ff ? eff_ctl.effort : ((lower > eff_high) ? eff_high : lower);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= eff_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_limited_effort = result_ff;

   a_result_under_high: assert property (@(posedge clock) disable iff (reset)
      (advance && eff_ctl.valid && enable_ff) |=> (rsp_limited_effort <= $past(eff_high)))
      else $error("clamped effort above high effort bound");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule
